// File: rtl/core/mfa_pkg.sv
// Package: shared types and constants of the mixed fraction ALU.
package mfa_pkg;

	localparam int unsigned OpW = 3;
	localparam int unsigned ResW = 64;

	typedef enum logic [OpW-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EVAL = 3'd4
	} op_t;

	// Job handed from the front part to the back part: one division to run.
	typedef struct packed {
		logic signed [ResW-1:0] num;
		logic signed [ResW-1:0] den;
		logic is_eval;
		logic is_null;
	} job_t;

endpackage

// File: rtl/core/mixed_fraction_alu.sv
// Top level: mixed fraction arithmetic unit, queue-style ports on both sides.
//
// Usage:
//   Input queue: drive op and both operands and raise push; the request is
//   taken at a rising edge where push is high and full is low.
//   Result queue: while empty is low the oldest result sits on res_whole,
//   res_num, res_den and div_zero; raise pop to take it.
// Operation codes: add, subtract, multiply, divide, evaluate the first
//   operand. Codes above evaluate return an all-zero result.
// Path: front part (operand products, improper numerators, cross products),
//   then the queue, then the divider (magnitude, 64 one-bit restoring steps,
//   sign fix and output register).
// Throughput: one request per cycle while pop keeps up; the divider is a
//   full pipeline, one quotient bit per stage, so nothing iterates in place.
// Reset: arst_n low empties every stage and the queue at once; no clearing
//   pass is needed. Payload registers are not reset.
// Stall: when pop stays low, the divider holds its output, the queue between
//   front and back fills, then the front part stops and full rises.
//   Results are never dropped or repeated.
module mixed_fraction_alu #(
	parameter int OPERAND_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] op,
	input logic [15:0] a_whole,
	input logic [15:0] a_num,
	input logic [15:0] a_den,
	input logic [15:0] b_whole,
	input logic [15:0] b_num,
	input logic [15:0] b_den,
	output logic empty,
	input logic pop,
	output logic signed [63:0] res_whole,
	output logic signed [63:0] res_num,
	output logic signed [63:0] res_den,
	output logic div_zero
);
	logic f_ready, f_valid, q_wready, q_valid, d_ready, d_valid;
	mfa_pkg::job_t f_job, q_job;

	assign full = !f_ready;
	assign empty = !d_valid;

	mfa_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready(f_ready),
		.op, .a_whole, .a_num, .a_den, .b_whole, .b_num, .b_den,
		.job_valid(f_valid), .job_ready(q_wready), .job(f_job)
	);

	mfa_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(q_wready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(d_ready), .rd_data(q_job)
	);

	mfa_divider u_div (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(d_ready), .job(q_job),
		.out_valid(d_valid), .out_ready(pop),
		.res_whole, .res_num, .res_den, .div_zero
	);

endmodule

// File: rtl/core/mfa_front.sv
// Front part: classify the op, form result numerator and denominator in stages.
module mfa_front #(
	parameter int OPERAND_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] op,
	input logic [15:0] a_whole,
	input logic [15:0] a_num,
	input logic [15:0] a_den,
	input logic [15:0] b_whole,
	input logic [15:0] b_num,
	input logic [15:0] b_den,
	output logic job_valid,
	input logic job_ready,
	output mfa_pkg::job_t job
);
	localparam int OB = OPERAND_BITS;
	localparam int IW = 2 * OB + 1;

	logic signed [OB-1:0] aw, an, ad, bw, bn, bd;
	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [2:0] op_s1, op_s2;
	logic signed [OB-1:0] an_s1, ad_s1, bn_s1, bd_s1, ad_s2, bd_s2;
	logic signed [2*OB-1:0] ap_s1, bp_s1;
	logic signed [IW-1:0] ai_s2, bi_s2;
	logic signed [63:0] p0_s3, p1_s3, rd_s3;
	logic [2:0] op_s3;
	logic signed [63:0] rn;

	assign aw = OB'(a_whole);
	assign an = OB'(a_num);
	assign ad = OB'(a_den);
	assign bw = OB'(b_whole);
	assign bn = OB'(b_num);
	assign bd = OB'(b_den);

	// Whole pipe advances unless the last stage holds a job that cannot leave.
	assign adv = !v_s3 || job_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op;
			an_s1 <= an;
			ad_s1 <= ad;
			bn_s1 <= bn;
			bd_s1 <= bd;
			ap_s1 <= ad * aw;
			bp_s1 <= bd * bw;
			op_s2 <= op_s1;
			ad_s2 <= ad_s1;
			bd_s2 <= bd_s1;
			ai_s2 <= IW'(ap_s1) + IW'(an_s1);
			bi_s2 <= IW'(bp_s1) + IW'(bn_s1);
			op_s3 <= op_s2;
			case (op_s2)
				mfa_pkg::OP_MUL: begin
					p0_s3 <= 64'(ai_s2) * 64'(bi_s2);
					p1_s3 <= '0;
					rd_s3 <= 64'(ad_s2) * 64'(bd_s2);
				end
				mfa_pkg::OP_DIV: begin
					p0_s3 <= 64'(ai_s2) * 64'(bd_s2);
					p1_s3 <= '0;
					rd_s3 <= 64'(ad_s2) * 64'(bi_s2);
				end
				mfa_pkg::OP_EVAL: begin
					p0_s3 <= 64'(ai_s2);
					p1_s3 <= '0;
					rd_s3 <= 64'(ad_s2);
				end
				default: begin
					p0_s3 <= 64'(ai_s2) * 64'(bd_s2);
					p1_s3 <= 64'(bi_s2) * 64'(ad_s2);
					rd_s3 <= 64'(ad_s2) * 64'(bd_s2);
				end
			endcase
		end
	end

	always_comb begin
		case (op_s3)
			mfa_pkg::OP_SUB: rn = p0_s3 - p1_s3;
			default: rn = p0_s3 + p1_s3;
		endcase
	end

	assign job_valid = v_s3;
	assign job.num = rn;
	assign job.den = rd_s3;
	assign job.is_eval = (op_s3 == mfa_pkg::OP_EVAL);
	assign job.is_null = (op_s3 > mfa_pkg::OP_EVAL);

endmodule

// File: rtl/core/mfa_fifo.sv
// Short queue between front and back parts.
module mfa_fifo #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input mfa_pkg::job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output mfa_pkg::job_t rd_data
);
	localparam int AW = $clog2(DEPTH);
	mfa_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");

endmodule

// File: rtl/core/mfa_divider.sv
// Back part: pipelined radix-2 signed divider, one quotient bit per stage.
module mfa_divider (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mfa_pkg::job_t job,
	output logic out_valid,
	input logic out_ready,
	output logic signed [63:0] res_whole,
	output logic signed [63:0] res_num,
	output logic signed [63:0] res_den,
	output logic div_zero
);
	localparam int W = 64;
	localparam int N = W + 1;

	logic adv;
	logic vl_q [N+1];
	logic [W-1:0] rem_q [N+1];
	logic [W-1:0] quo_q [N+1];
	logic [W-1:0] dv_q [N+1];
	logic [W-1:0] den_q [N+1];
	logic qn_q [N+1], rn_q [N+1], ev_q [N+1], nl_q [N+1], dz_q [N+1];
	logic [W-1:0] q_f, r_f;

	// Pipe advances whenever the output register is free or being emptied.
	assign adv = !vl_q[N] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) vl_q[i] <= 1'b0;
		end else if (adv) begin
			vl_q[0] <= in_valid;
			for (int i = 1; i <= N; i++) vl_q[i] <= vl_q[i-1];
		end
	end

	// Stage 0: take magnitudes; stages 1..64: restoring steps; stage 65: sign fix.
	always_ff @(posedge clk) begin
		if (adv) begin
			quo_q[0] <= job.num[W-1] ? W'(-job.num) : W'(job.num);
			dv_q[0] <= job.den[W-1] ? W'(-job.den) : W'(job.den);
			rem_q[0] <= '0;
			den_q[0] <= job.den;
			qn_q[0] <= job.num[W-1] ^ job.den[W-1];
			rn_q[0] <= job.num[W-1];
			ev_q[0] <= job.is_eval;
			nl_q[0] <= job.is_null;
			dz_q[0] <= (job.den == '0) && !job.is_null;
			for (int i = 1; i < N; i++) begin
				logic [W:0] t;
				t = {rem_q[i-1], quo_q[i-1][W-1]};
				if (t >= {1'b0, dv_q[i-1]}) begin
					rem_q[i] <= W'(t - {1'b0, dv_q[i-1]});
					quo_q[i] <= {quo_q[i-1][W-2:0], 1'b1};
				end else begin
					rem_q[i] <= t[W-1:0];
					quo_q[i] <= {quo_q[i-1][W-2:0], 1'b0};
				end
				dv_q[i] <= dv_q[i-1];
				den_q[i] <= den_q[i-1];
				qn_q[i] <= qn_q[i-1];
				rn_q[i] <= rn_q[i-1];
				ev_q[i] <= ev_q[i-1];
				nl_q[i] <= nl_q[i-1];
				dz_q[i] <= dz_q[i-1];
			end
			if (nl_q[N-1] || dz_q[N-1]) begin
				quo_q[N] <= '0;
				rem_q[N] <= '0;
				den_q[N] <= '0;
			end else begin
				quo_q[N] <= q_f;
				rem_q[N] <= ev_q[N-1] ? '0 : r_f;
				den_q[N] <= ev_q[N-1] ? W'(1) : den_q[N-1];
			end
			dz_q[N] <= dz_q[N-1];
			dv_q[N] <= '0;
			qn_q[N] <= 1'b0;
			rn_q[N] <= 1'b0;
			ev_q[N] <= 1'b0;
			nl_q[N] <= 1'b0;
		end
	end

	assign q_f = qn_q[N-1] ? W'(-quo_q[N-1]) : quo_q[N-1];
	assign r_f = rn_q[N-1] ? W'(-rem_q[N-1]) : rem_q[N-1];

	assign out_valid = vl_q[N];
	assign res_whole = quo_q[N];
	assign res_num = rem_q[N];
	assign res_den = den_q[N];
	assign div_zero = dz_q[N];

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_whole == '0 && res_den == '0)
		else $error("zero divisor result not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_whole))
		else $error("stalled result changed");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_zero && res_den != '0 |->
		(res_num[W-1] ? W'(-res_num) : res_num) <
		(res_den[W-1] ? W'(-res_den) : res_den))
		else $error("remainder not below divisor");

endmodule
